### hdl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

   // operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // request word
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } req_type;

   // response word
   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               found;
      logic [1:0]         status;
   } rsp_type;

   // control sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SEARCH
   } state_type;

endpackage

### hdl/bdq_ram.sv
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bounded_deque_with_search_core.sv
`timescale 1ns / 1ps

// channel   ports                          direction  handshake
// request   start, busy, req_data          in         taken when start & !busy
// response  rsp_valid, rsp_data            out        one-cycle strobe, no back-pressure
//
// A push, an unused op, a pop on an empty store and a search of an empty store never raise
// busy: a new word may follow in the next cycle. A pop holds busy in S_POP while the
// registered store read completes. A search reads one entry a cycle through the single read
// port, holding busy until a hit or until every stored entry has been compared.
// Every response strobes in the cycle after the word's work ends; the receiver cannot stall.
// Synchronous reset empties the store (front and count to zero) with no clearing pass.
module bounded_deque_with_search_core #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bdq_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output bdq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   bdq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      off_ff, off_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [31:0]        val_ff, val_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;
   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic               issue;
   logic [AW-1:0]      pos_back;
   logic [AW-1:0]      pos_last;
   logic [AW-1:0]      pos_next;

   // ring position off entries past the front
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [SW-1:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   bdq_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept   = start && (state_ff == bdq_pkg::S_IDLE);
   assign busy     = (state_ff != bdq_pkg::S_IDLE);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign issue    = (off_ff != count_ff);
   assign pos_back = ring_pos(front_ff, AW'(count_ff));
   assign pos_last = ring_pos(front_ff, AW'(count_ff - CW'(1)));
   assign pos_next = (pos_ff == AW'(DEPTH - 1)) ? '0 : pos_ff + AW'(1);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // next state, memory accesses and response
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      pos_in       = pos_ff;
      rd_pend_in   = 1'b0;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_back;
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_data_in.popped_value = '0;
               rsp_data_in.found        = 1'b0;
               rsp_data_in.status       = bdq_pkg::STATUS_OK;
               rsp_valid_in             = 1'b1;
               val_in                   = req_data.value;
               case (req_data.op)
                  bdq_pkg::OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_data_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bdq_pkg::OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_data_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = pos_back;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bdq_pkg::OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_data_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = front_ff;
                        front_in     = ring_pos(front_ff, AW'(1));
                        count_in     = count_ff - CW'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = bdq_pkg::S_POP;
                     end
                  end
                  bdq_pkg::OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_data_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = pos_last;
                        count_in     = count_ff - CW'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = bdq_pkg::S_POP;
                     end
                  end
                  bdq_pkg::OP_SEARCH: begin
                     // an empty store answers at once with no hit
                     if (!is_empty) begin
                        off_in       = '0;
                        pos_in       = front_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = bdq_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bdq_pkg::S_POP: begin
            // read data has arrived from the store
            rsp_data_in.popped_value = rd_data;
            rsp_valid_in             = 1'b1;
            state_in                 = bdq_pkg::S_IDLE;
         end
         bdq_pkg::S_SEARCH: begin
            // one read issued and one compare done per cycle
            rd_en   = issue;
            rd_addr = pos_ff;
            if (issue) begin
               off_in = off_ff + CW'(1);
               pos_in = pos_next;
            end
            rd_pend_in = issue;
            if (rd_pend_ff && (rd_data == val_ff)) begin
               rsp_data_in.found = 1'b1;
               rsp_valid_in      = 1'b1;
               rd_pend_in        = 1'b0;
               state_in          = bdq_pkg::S_IDLE;
            end else if (rd_pend_ff && !issue) begin
               rsp_valid_in = 1'b1;
               state_in     = bdq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bdq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### bench/tb_bounded_deque_with_search_core.sv
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_core;

   localparam int DEPTH = 256;

   // op codes the block ignores
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // sender idle modes, percent of cycles
   localparam int IDLE_LIGHT = 14;
   localparam int IDLE_HEAVY = 64;
   localparam int IDLE_NONE  = 0;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   bdq_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   bdq_pkg::rsp_type rsp_data;

   bounded_deque_with_search_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the deque
   logic signed [31:0] ring [DEPTH];
   int                 head = 0;
   int                 held = 0;

   // responses still owed by the block, oldest first
   bdq_pkg::rsp_type owed_rsp [$];

   int idle_pct  = IDLE_LIGHT;
   int n_bad     = 0;
   int n_checked = 0;
   int n_sent    = 0;
   int n_full    = 0;
   int n_empty   = 0;
   int n_hits    = 0;

   // directed table row: word, and a hand-written response where one is given
   typedef struct {
      bdq_pkg::req_type word;
      bit               fixed;
      bdq_pkg::rsp_type rsp;
   } stim_row_type;

   stim_row_type dir_rows [$];

   function automatic stim_row_type mk_row(logic [2:0] op, logic signed [31:0] value,
                                           bit fixed, logic signed [31:0] popped,
                                           logic found, logic [1:0] status);
      stim_row_type row;
      row.word.op           = op;
      row.word.value        = value;
      row.fixed             = fixed;
      row.rsp.popped_value  = popped;
      row.rsp.found         = found;
      row.rsp.status        = status;
      return row;
   endfunction

   // expected response for one word, updating the shadow deque
   function automatic bdq_pkg::rsp_type deque_predict(bdq_pkg::req_type w);
      bdq_pkg::rsp_type r;
      int               k;
      r = '0;
      r.status = bdq_pkg::STATUS_OK;
      case (w.op)
         bdq_pkg::OP_PUSH_FRONT: begin
            if (held == DEPTH) begin
               r.status = bdq_pkg::STATUS_FULL;
            end else begin
               head = (head == 0) ? DEPTH - 1 : head - 1;
               ring[head] = w.value;
               held++;
            end
         end
         bdq_pkg::OP_PUSH_BACK: begin
            if (held == DEPTH) begin
               r.status = bdq_pkg::STATUS_FULL;
            end else begin
               ring[(head + held) % DEPTH] = w.value;
               held++;
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (held == 0) begin
               r.status = bdq_pkg::STATUS_EMPTY;
            end else begin
               r.popped_value = ring[head];
               head = (head + 1) % DEPTH;
               held--;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (held == 0) begin
               r.status = bdq_pkg::STATUS_EMPTY;
            end else begin
               r.popped_value = ring[(head + held - 1) % DEPTH];
               held--;
            end
         end
         bdq_pkg::OP_SEARCH: begin
            for (k = 0; k < held; k++) begin
               if (ring[(head + k) % DEPTH] == w.value) begin
                  r.found = 1'b1;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // random data, weighted towards extremes and a small set for repeats
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2, 3:    return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // random word; push_w sets the share of pushes, spare codes and searches take fixed shares, pops the rest
   function automatic bdq_pkg::req_type pick_word(int push_w);
      bdq_pkg::req_type w;
      int               r;
      r = $urandom_range(0, 99);
      w.value = pick_value();
      if (r < 3) begin
         w.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end else if (r < 3 + push_w) begin
         w.op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
      end else if (r < 15 + push_w) begin
         w.op = bdq_pkg::OP_SEARCH;
         if (held > 0 && $urandom_range(0, 9) < 6)
            w.value = ring[(head + $urandom_range(0, held - 1)) % DEPTH];
      end else begin
         w.op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
      end
      return w;
   endfunction

   // offer one word, with a random gap first, and wait until it is taken
   task automatic send_word(bdq_pkg::req_type w, bit fixed, bdq_pkg::rsp_type fix_rsp);
      bdq_pkg::rsp_type guess;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      guess = deque_predict(w);
      owed_rsp.push_back(fixed ? fix_rsp : guess);
      n_sent++;
      if (guess.status == bdq_pkg::STATUS_FULL)
         n_full++;
      if (guess.status == bdq_pkg::STATUS_EMPTY)
         n_empty++;
      if (guess.found)
         n_hits++;
   endtask

   // hold the sender off until every owed response has arrived
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (owed_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic note_bad(string what, bdq_pkg::rsp_type want);
      n_bad++;
      if (n_bad <= 10) begin
         $display("%s at response %0d: expected popped %0d found %0b status %0d,",
                  what, n_checked, want.popped_value, want.found, want.status);
         $display("   got popped %0d found %0b status %0d",
                  rsp_data.popped_value, rsp_data.found, rsp_data.status);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      bdq_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_rsp.size() == 0) begin
            note_bad("unexpected response", '0);
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.popped_value !== want.popped_value ||
                rsp_data.found !== want.found ||
                rsp_data.status !== want.status)
               note_bad("mismatch", want);
         end
         n_checked++;
      end
   end

   // stimulus
   initial begin
      bdq_pkg::req_type w;
      int               i;

      // directed words: empty store, extremes, wrap of the front pointer, spare codes
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_FRONT, 0, 1, 0, 0, bdq_pkg::STATUS_EMPTY));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_BACK, 0, 1, 0, 0, bdq_pkg::STATUS_EMPTY));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 0, 1, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(OP_SPARE_FIRST, -1, 1, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(OP_SPARE_LAST, 32'sh7fff_ffff, 1, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, 1, 0, 0,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_BACK, 32'sh8000_0000, 1, 0, 0,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 32'sh8000_0000, 1, 0, 1,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 32'sh7fff_ffff, 1, 0, 1,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 0, 1, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_FRONT, -1, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_BACK, 0, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, -1, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_FRONT, 0, 1, -1, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_BACK, 0, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_FRONT, 0, 1, 32'sh7fff_ffff, 0,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_BACK, 0, 1, 32'sh8000_0000, 0,
                                bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_BACK, 0, 1, 0, 0, bdq_pkg::STATUS_EMPTY));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_BACK, 5, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_BACK, 6, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_PUSH_BACK, 7, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 7, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_SEARCH, 8, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_FRONT, 0, 0, 0, 0, bdq_pkg::STATUS_OK));
      dir_rows.push_back(mk_row(bdq_pkg::OP_POP_BACK, 0, 0, 0, 0, bdq_pkg::STATUS_OK));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, light sender idling
      idle_pct = IDLE_LIGHT;
      foreach (dir_rows[i])
         send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].rsp);
      wait_drained();

      // balanced random traffic
      for (i = 0; i < 40; i++)
         send_word(pick_word(45), 0, '0);
      wait_drained();

      // fill to full under heavy sender idling
      idle_pct = IDLE_HEAVY;
      while (held < DEPTH)
         send_word(pick_word(85), 0, '0);

      // work the full store with no idling
      idle_pct = IDLE_NONE;
      for (i = 0; i < 20; i++)
         send_word(pick_word(85), 0, '0);
      wait_drained();

      // drain part way, pops weighted
      for (i = 0; i < 40; i++)
         send_word(pick_word(10), 0, '0);

      // let any late response show itself
      wait_drained();
      repeat (DEPTH + 8) @(posedge clock);

      $display("sent %0d words, checked %0d responses", n_sent, n_checked);
      $display("refused pushes %0d, pops on empty %0d, search hits %0d",
               n_full, n_empty, n_hits);
      if (n_bad == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d bad responses", n_bad);
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", owed_rsp.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
